// File: rtl/core/skv_pkg.sv
// Shared codes and types for the sorted key/value table.
package skv_pkg;

	localparam int KEY_W = 16;
	localparam int VAL_W = 16;
	localparam int OP_W  = 2;
	localparam int ST_W  = 3;

	localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
	localparam logic [OP_W-1:0] OP_FIND   = 2'd1;
	localparam logic [OP_W-1:0] OP_DELETE = 2'd2;

	localparam logic [ST_W-1:0] ST_INSERTED  = 3'd0;
	localparam logic [ST_W-1:0] ST_DUPLICATE = 3'd1;
	localparam logic [ST_W-1:0] ST_FULL      = 3'd2;
	localparam logic [ST_W-1:0] ST_FOUND     = 3'd3;
	localparam logic [ST_W-1:0] ST_NOT_FOUND = 3'd4;
	localparam logic [ST_W-1:0] ST_DELETED   = 3'd5;
	localparam logic [ST_W-1:0] ST_EMPTY     = 3'd6;

	typedef struct packed {
		logic signed [KEY_W-1:0] key;
		logic [VAL_W-1:0]        value;
	} entry_t;

	// update broadcast to every cell
	typedef struct packed {
		logic ins;
		logic del;
	} cmd_t;

endpackage

// File: rtl/core/skv_cell.sv
// One slot of the sorted chain: holds an entry, compares it, shifts left or right.
module skv_cell #(
	parameter int IDX   = 0,
	parameter int CNT_W = 5
) (
	input  logic                              clk,
	input  logic [CNT_W-1:0]                  fill,
	input  skv_pkg::cmd_t                     cmd,
	input  logic signed [skv_pkg::KEY_W-1:0]  req_key,
	input  logic [skv_pkg::VAL_W-1:0]         req_value,
	input  skv_pkg::entry_t                   left_entry,
	input  logic                              left_lt,
	input  skv_pkg::entry_t                   right_entry,
	output skv_pkg::entry_t                   entry,
	output logic                              lt,
	output logic                              eq
);

	skv_pkg::entry_t entry_q;
	logic            held;

	assign held  = CNT_W'(IDX) < fill;
	assign lt    = held && (entry_q.key < req_key);
	assign eq    = held && (entry_q.key == req_key);
	assign entry = entry_q;

	// cells below the insert/delete point keep their entry
	always_ff @(posedge clk) begin
		if (cmd.ins && !lt) begin
			if (left_lt) begin
				entry_q.key   <= req_key;
				entry_q.value <= req_value;
			end else begin
				entry_q <= left_entry;
			end
		end else if (cmd.del && !lt) begin
			entry_q <= right_entry;
		end
	end

endmodule

// File: rtl/core/sorted_key_value_table_unit.sv
// Top level of the sorted key/value table: request control, cell chain, result register.
//
//  channel | valid     | stall     | payload
//  --------+-----------+-----------+---------------------------------
//  request | req_valid | req_stall | op, key, value
//  result  | rsp_valid | rsp_stall | status, found_value, entry_count
//
// A request is first captured into registers; then every cell compares against
// the key in parallel and the chain shifts to insert or delete.
// A new request is taken while a result waits in the output register.
// Reset clears the fill count and control; cell and result contents stay undefined.
// A stalled result holds the execute cycle back, and with it the request side.
module sorted_key_value_table_unit #(
	parameter int DEPTH = 16,
	localparam int CNT_W = $clog2(DEPTH + 1)
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              req_valid,
	output logic                              req_stall,
	input  logic [skv_pkg::OP_W-1:0]          op,
	input  logic signed [skv_pkg::KEY_W-1:0]  key,
	input  logic [skv_pkg::VAL_W-1:0]         value,
	output logic                              rsp_valid,
	input  logic                              rsp_stall,
	output logic [skv_pkg::ST_W-1:0]          status,
	output logic [skv_pkg::VAL_W-1:0]         found_value,
	output logic [CNT_W-1:0]                  entry_count
);

	logic                              exec_q;
	logic [skv_pkg::OP_W-1:0]          op_q;
	logic signed [skv_pkg::KEY_W-1:0]  key_q;
	logic [skv_pkg::VAL_W-1:0]         value_q;
	logic [CNT_W-1:0]                  fill_q;

	logic                              rsp_valid_q;
	logic [skv_pkg::ST_W-1:0]          status_q;
	logic [skv_pkg::VAL_W-1:0]         found_value_q;
	logic [CNT_W-1:0]                  count_q;

	skv_pkg::entry_t                   entries [DEPTH];
	logic [DEPTH-1:0]                  lt_vec;
	logic [DEPTH-1:0]                  eq_vec;
	skv_pkg::cmd_t                     cmd;

	logic                              go;
	logic                              any_eq;
	logic                              full;
	logic                              empty;
	logic [skv_pkg::VAL_W-1:0]         match_value;
	logic [skv_pkg::ST_W-1:0]          next_status;
	logic [CNT_W-1:0]                  next_fill;

	assign req_stall = exec_q;
	assign go        = exec_q && (!rsp_valid_q || !rsp_stall);

	always_ff @(posedge clk) begin
		if (req_valid && !req_stall) begin
			op_q    <= op;
			key_q   <= key;
			value_q <= value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exec_q <= 1'b0;
		end else if (req_valid && !req_stall) begin
			exec_q <= 1'b1;
		end else if (go) begin
			exec_q <= 1'b0;
		end
	end

	genvar gi;
	generate
		for (gi = 0; gi < DEPTH; gi++) begin : g_cell
			skv_pkg::entry_t left_e;
			skv_pkg::entry_t right_e;
			logic            left_l;

			if (gi == 0) begin : g_first
				assign left_e = entries[gi];
				assign left_l = 1'b1;
			end else begin : g_mid
				assign left_e = entries[gi-1];
				assign left_l = lt_vec[gi-1];
			end

			if (gi == DEPTH - 1) begin : g_last
				assign right_e = entries[gi];
			end else begin : g_inner
				assign right_e = entries[gi+1];
			end

			skv_cell #(
				.IDX   (gi),
				.CNT_W (CNT_W)
			) u_cell (
				.clk         (clk),
				.fill        (fill_q),
				.cmd         (cmd),
				.req_key     (key_q),
				.req_value   (value_q),
				.left_entry  (left_e),
				.left_lt     (left_l),
				.right_entry (right_e),
				.entry       (entries[gi]),
				.lt          (lt_vec[gi]),
				.eq          (eq_vec[gi])
			);
		end
	endgenerate

	// keys are unique, so at most one cell matches
	always_comb begin
		match_value = '0;
		for (int i = 0; i < DEPTH; i++) begin
			if (eq_vec[i]) begin
				match_value = match_value | entries[i].value;
			end
		end
	end

	assign any_eq = |eq_vec;
	assign full   = fill_q == CNT_W'(DEPTH);
	assign empty  = fill_q == '0;

	always_comb begin
		cmd         = '0;
		next_status = skv_pkg::ST_NOT_FOUND;
		next_fill   = fill_q;
		case (op_q)
			skv_pkg::OP_INSERT: begin
				if (any_eq) begin
					next_status = skv_pkg::ST_DUPLICATE;
				end else if (full) begin
					next_status = skv_pkg::ST_FULL;
				end else begin
					next_status = skv_pkg::ST_INSERTED;
					cmd.ins     = go;
					next_fill   = fill_q + CNT_W'(1);
				end
			end
			skv_pkg::OP_FIND: begin
				if (empty) begin
					next_status = skv_pkg::ST_EMPTY;
				end else if (any_eq) begin
					next_status = skv_pkg::ST_FOUND;
				end
			end
			skv_pkg::OP_DELETE: begin
				if (empty) begin
					next_status = skv_pkg::ST_EMPTY;
				end else if (any_eq) begin
					next_status = skv_pkg::ST_DELETED;
					cmd.del     = go;
					next_fill   = fill_q - CNT_W'(1);
				end
			end
			default: begin
				next_status = skv_pkg::ST_NOT_FOUND;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q      <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (go) begin
				fill_q      <= next_fill;
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			status_q      <= next_status;
			found_value_q <= (next_status == skv_pkg::ST_FOUND) ? match_value : '0;
			count_q       <= next_fill;
		end
	end

	assign rsp_valid   = rsp_valid_q;
	assign status      = status_q;
	assign found_value = found_value_q;
	assign entry_count = count_q;

endmodule
